@@ src/fpwb_pkg.sv @@
// Shared constants and types for the flash page write buffer.
package fpwb_pkg;

  // Field widths of the command and response channels
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned ADDR_W = 12;
  localparam int unsigned DATA_W = 8;

  // Default geometry of the managed flash region
  localparam int unsigned PAGE_BYTES_DEF   = 512;
  localparam int unsigned REGION_PAGES_DEF = 8;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

  // Value of an erased flash byte
  localparam logic [DATA_W-1:0] ERASED_BYTE = 8'hFF;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LOOK  = 6'b000010,
    ST_WBACK = 6'b000100,
    ST_LOAD  = 6'b001000,
    ST_STORE = 6'b010000,
    ST_RESP  = 6'b100000
  } fpwb_state_e;

  // Status of the page walker seen by the sequencer
  typedef struct packed {
    logic busy;
    logic wr_en;
    logic done;
  } walk_stat_t;

endpackage

@@ src/fpwb_if.sv @@
// Valid/ready channel interfaces for commands and responses.
interface fpwb_cmd_if;
  import fpwb_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, output command, output address, output write_data,
                  input ready);
  modport sink (input valid, input command, input address, input write_data,
                output ready);
endinterface

interface fpwb_rsp_if;
  import fpwb_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              page_hit;
  logic              wrote_back;

  modport source (output valid, output read_data, output page_hit, output wrote_back,
                  input ready);
  modport sink (input valid, input read_data, input page_hit, input wrote_back,
                output ready);
endinterface

@@ src/flash_page_write_buffer.sv @@
// Top level of the single-page write-back buffer in front of a flash region.
//
//   channel | dir | fields                              | transfer when
//   cmd_i   | in  | command, address, write_data        | cmd_i.valid & cmd_i.ready
//   rsp_o   | out | read_data, page_hit, wrote_back      | rsp_o.valid & rsp_o.ready
//
// One command at a time. A read looks up the buffer or the flash, and a write hit
// writes the buffer directly; a flush of a valid buffer writes the page back,
// a write miss on an empty buffer loads the new page, and a write miss on a
// valid buffer writes back and then loads: the page walker copies one byte per cycle
// through the single read port of each RAM.
// Reset clears the sequencer, the buffer valid flag and the per-page
// "programmed" flags; a page never programmed reads as erased, so no
// clearing pass runs. A new command is taken while a response still waits.
module flash_page_write_buffer import fpwb_pkg::*; #(
  parameter int unsigned PAGE_BYTES   = PAGE_BYTES_DEF,
  parameter int unsigned REGION_PAGES = REGION_PAGES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fpwb_cmd_if.sink   cmd_i,
  fpwb_rsp_if.source rsp_o
);

  localparam int unsigned PAGE_BITS = $clog2(PAGE_BYTES);
  localparam int unsigned PG_W      = (REGION_PAGES > 1) ? $clog2(REGION_PAGES) : 1;
  localparam int unsigned NPG       = 1 << PG_W;
  localparam int unsigned FL_W      = PG_W + PAGE_BITS;

  fpwb_state_e state_q, state_d;

  // Buffer bookkeeping
  logic                 bvalid_q;
  logic [PG_W-1:0]      bpage_q;
  logic [NPG-1:0]       pg_wr_q;

  // Latched command
  logic [CMD_W-1:0]     cmd_q;
  logic [PG_W-1:0]      pg_q;
  logic [PAGE_BITS-1:0] off_q;
  logic [DATA_W-1:0]    data_q;
  logic                 hit_q;
  logic                 wb_q;
  logic [DATA_W-1:0]    rd_q;

  // Response register
  logic                 out_valid_q;
  logic [DATA_W-1:0]    out_rd_q;
  logic                 out_hit_q;
  logic                 out_wb_q;
  logic                 out_free;

  // Decode of the incoming command
  logic                 acc;
  logic [ADDR_W-1:0]    a_page;
  logic                 a_in;
  logic [PG_W-1:0]      a_pg;
  logic [PAGE_BITS-1:0] a_off;
  logic                 a_hit;

  // RAM ports and walker
  logic                 buf_we;
  logic [PAGE_BITS-1:0] buf_waddr;
  logic [DATA_W-1:0]    buf_wdata;
  logic [PAGE_BITS-1:0] buf_raddr;
  logic [DATA_W-1:0]    buf_rdata;
  logic                 fl_we;
  logic [FL_W-1:0]      fl_waddr;
  logic [FL_W-1:0]      fl_raddr;
  logic [DATA_W-1:0]    fl_rdata;
  logic                 walk_start;
  logic [PAGE_BITS-1:0] walk_rd_idx;
  logic [PAGE_BITS-1:0] walk_wr_idx;
  walk_stat_t           walk_stat;

  assign cmd_i.ready = (state_q == ST_IDLE);
  assign acc         = cmd_i.valid & cmd_i.ready;
  assign a_page      = cmd_i.address >> PAGE_BITS;
  assign a_in        = (a_page < ADDR_W'(REGION_PAGES));
  assign a_pg        = a_page[PG_W-1:0];
  assign a_off       = cmd_i.address[PAGE_BITS-1:0];
  assign a_hit       = a_in & bvalid_q & (bpage_q == a_pg);
  assign out_free    = ~out_valid_q | rsp_o.ready;

  // Sequencer and RAM port steering
  always_comb begin
    state_d    = state_q;
    walk_start = 1'b0;
    buf_we     = 1'b0;
    buf_waddr  = off_q;
    buf_wdata  = data_q;
    buf_raddr  = walk_rd_idx;
    fl_we      = 1'b0;
    fl_waddr   = {bpage_q, walk_wr_idx};
    fl_raddr   = {pg_q, walk_rd_idx};
    unique case (state_q)
      ST_IDLE: begin
        buf_raddr = a_off;
        fl_raddr  = {a_pg, a_off};
        if (acc) begin
          state_d = ST_RESP;
          if (cmd_i.command == CMD_READ) begin
            if (a_in) begin
              state_d = ST_LOOK;
            end
          end else if (cmd_i.command == CMD_WRITE) begin
            if (a_hit) begin
              buf_we    = 1'b1;
              buf_waddr = a_off;
              buf_wdata = cmd_i.write_data;
            end else if (a_in) begin
              walk_start = 1'b1;
              state_d    = bvalid_q ? ST_WBACK : ST_LOAD;
            end
          end else if (cmd_i.command == CMD_FLUSH) begin
            if (bvalid_q) begin
              walk_start = 1'b1;
              state_d    = ST_WBACK;
            end
          end
        end
      end
      ST_LOOK: begin
        state_d = ST_RESP;
      end
      ST_WBACK: begin
        fl_we = walk_stat.wr_en;
        if (walk_stat.done) begin
          if (cmd_q == CMD_WRITE) begin
            walk_start = 1'b1;
            state_d    = ST_LOAD;
          end else begin
            state_d = ST_RESP;
          end
        end
      end
      ST_LOAD: begin
        buf_we    = walk_stat.wr_en;
        buf_waddr = walk_wr_idx;
        buf_wdata = pg_wr_q[pg_q] ? fl_rdata : ERASED_BYTE;
        if (walk_stat.done) begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        buf_we  = 1'b1;
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bvalid_q    <= 1'b0;
      bpage_q     <= '0;
      pg_wr_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // Mark the written-back page programmed
      if (state_q == ST_WBACK) begin
        pg_wr_q[bpage_q] <= 1'b1;
      end
      // Drop the buffer after a flush
      if (state_q == ST_WBACK && walk_stat.done && cmd_q != CMD_WRITE) begin
        bvalid_q <= 1'b0;
        bpage_q  <= '0;
      end
      // Take ownership of the newly loaded page
      if (state_q == ST_STORE) begin
        bvalid_q <= 1'b1;
        bpage_q  <= pg_q;
      end
      if (state_q == ST_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Command and result payload
  always_ff @(posedge clk_i) begin
    if (acc) begin
      cmd_q  <= cmd_i.command;
      pg_q   <= a_pg;
      off_q  <= a_off;
      data_q <= cmd_i.write_data;
      hit_q  <= a_hit & (cmd_i.command == CMD_READ || cmd_i.command == CMD_WRITE ||
                         cmd_i.command == CMD_FLUSH);
      rd_q   <= '0;
      wb_q   <= bvalid_q & ((cmd_i.command == CMD_FLUSH) ||
                            (cmd_i.command == CMD_WRITE && a_in && !a_hit));
    end
    if (state_q == ST_LOOK) begin
      if (hit_q) begin
        rd_q <= buf_rdata;
      end else begin
        rd_q <= pg_wr_q[pg_q] ? fl_rdata : ERASED_BYTE;
      end
    end
    if (state_q == ST_RESP && out_free) begin
      out_rd_q  <= rd_q;
      out_hit_q <= hit_q;
      out_wb_q  <= wb_q;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.read_data  = out_rd_q;
  assign rsp_o.page_hit   = out_hit_q;
  assign rsp_o.wrote_back = out_wb_q;

  fpwb_walk #(
    .PAGE_BITS(PAGE_BITS)
  ) u_walk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (walk_start),
    .rd_idx_o(walk_rd_idx),
    .wr_idx_o(walk_wr_idx),
    .stat_o  (walk_stat)
  );

  fpwb_ram #(
    .WIDTH(DATA_W),
    .DEPTH(1 << PAGE_BITS)
  ) u_page_buf (
    .clk_i  (clk_i),
    .we_i   (buf_we),
    .waddr_i(buf_waddr),
    .wdata_i(buf_wdata),
    .raddr_i(buf_raddr),
    .rdata_o(buf_rdata)
  );

  fpwb_ram #(
    .WIDTH(DATA_W),
    .DEPTH(1 << FL_W)
  ) u_flash (
    .clk_i  (clk_i),
    .we_i   (fl_we),
    .waddr_i(fl_waddr),
    .wdata_i(buf_rdata),
    .raddr_i(fl_raddr),
    .rdata_o(fl_rdata)
  );

endmodule

@@ src/fpwb_ram.sv @@
// Generic simple dual-port RAM with registered read data.
module fpwb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/fpwb_walk.sv @@
// Page walker: steps a byte index over one page, read then delayed write.
module fpwb_walk import fpwb_pkg::*; #(
  parameter int unsigned PAGE_BITS = 9
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic [PAGE_BITS-1:0] rd_idx_o,
  output logic [PAGE_BITS-1:0] wr_idx_o,
  output walk_stat_t           stat_o
);

  logic [PAGE_BITS:0]   idx_q;
  logic                 busy_q;
  logic                 pend_q;
  logic [PAGE_BITS-1:0] pidx_q;
  logic                 issue;

  // Issue a read while the index is still inside the page
  assign issue = busy_q & ~idx_q[PAGE_BITS];

  // Advance the index; the write follows in the cycle after its read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pend_q <= 1'b0;
      idx_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      pend_q <= 1'b0;
      idx_q  <= '0;
    end else if (busy_q) begin
      if (issue) begin
        idx_q <= idx_q + 1'b1;
      end
      pend_q <= issue;
      if (!issue && !pend_q) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Hold the index of the read in flight
  always_ff @(posedge clk_i) begin
    pidx_q <= idx_q[PAGE_BITS-1:0];
  end

  assign rd_idx_o     = idx_q[PAGE_BITS-1:0];
  assign wr_idx_o     = pidx_q;
  assign stat_o.busy  = busy_q;
  assign stat_o.wr_en = pend_q;
  assign stat_o.done  = busy_q & ~issue & ~pend_q;

endmodule
